// File: hw/rtl/bertlv_pkg.sv
// shared types and constants for the tlv tag search block
// no dependencies

package bertlv_pkg;

  localparam int unsigned DefMaxValueLen = 50;
  localparam int unsigned DefMaxEntries  = 100;

  localparam logic [4:0] TagLongForm = 5'h1f;

  // parser phase codes
  localparam logic [2:0] PhTag1 = 3'd0;
  localparam logic [2:0] PhTag2 = 3'd1;
  localparam logic [2:0] PhLen  = 3'd2;
  localparam logic [2:0] PhSkip = 3'd3;
  localparam logic [2:0] PhCopy = 3'd4;
  localparam logic [2:0] PhDone = 3'd5;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_length;
    logic       found;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
  } item_t;

endpackage

// File: hw/rtl/ber_tlv_tag_search.sv
// tlv tag search top level: input register, parser, result register
// depends on bertlv_pkg, bertlv_in_stage, bertlv_parser, bertlv_out_stage
// a result passes the input register, the combinational parser and the result register before out_valid
// throughput: one byte per cycle while the output is not stalled by out_ready
// reset: synchronous rst clears both stage valid flags, parser state and the target register to 0
// no result is produced for skipped bytes, tag bytes that do not end the record, or bytes after the last result

module ber_tlv_tag_search #(
  parameter int unsigned MAX_VALUE_LEN = bertlv_pkg::DefMaxValueLen,
  parameter int unsigned MAX_ENTRIES   = bertlv_pkg::DefMaxEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] target_tag,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        record_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_length,
  output logic        found,
  output logic        last
);

  logic [15:0]         target;
  logic                advance;
  logic                held_valid;
  bertlv_pkg::item_t   in_item;
  bertlv_pkg::item_t   held_item;
  logic                res_valid;
  bertlv_pkg::result_t res;
  bertlv_pkg::result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= 16'd0;
    end else if (cfg_valid) begin
      target <= target_tag;
    end
  end

  assign advance              = !out_valid || out_ready;
  assign in_item.data_byte    = data_byte;
  assign in_item.record_start = record_start;

  bertlv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  bertlv_parser #(
    .MAX_VALUE_LEN (MAX_VALUE_LEN),
    .MAX_ENTRIES   (MAX_ENTRIES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (held_valid && advance),
    .target_tag (target),
    .item       (held_item),
    .res_valid  (res_valid),
    .res        (res)
  );

  bertlv_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .load      (held_valid && res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_byte  = out_res.out_byte;
  assign is_length = out_res.is_length;
  assign found     = out_res.found;
  assign last      = out_res.last;

endmodule

// File: hw/rtl/bertlv_in_stage.sv
// input register of the tlv tag search block
// depends on bertlv_pkg

module bertlv_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bertlv_pkg::item_t in_item,
  input  logic              advance,
  output logic              held_valid,
  output bertlv_pkg::item_t held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// File: hw/rtl/bertlv_parser.sv
// per-byte tlv parser state and next-state logic
// depends on bertlv_pkg

module bertlv_parser #(
  parameter int unsigned MAX_VALUE_LEN = bertlv_pkg::DefMaxValueLen,
  parameter int unsigned MAX_ENTRIES   = bertlv_pkg::DefMaxEntries
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [15:0]         target_tag,
  input  bertlv_pkg::item_t   item,
  output logic                res_valid,
  output bertlv_pkg::result_t res
);

  localparam logic [7:0] ValueLimit = 8'(MAX_VALUE_LEN);
  localparam logic [6:0] EntryLimit = 7'(MAX_ENTRIES);

  logic [2:0] phase;
  logic [7:0] tag_high;
  logic [7:0] bytes_left;
  logic [6:0] entries_seen;
  logic       is_match;

  logic [2:0] phase_next;
  logic [7:0] tag_high_next;
  logic [7:0] bytes_left_next;
  logic [6:0] entries_seen_next;
  logic       is_match_next;

  logic [2:0] cur_phase;
  logic [7:0] cur_tag_high;
  logic [7:0] cur_bytes_left;
  logic [6:0] cur_entries;
  logic       cur_match;
  logic [7:0] b;
  logic [7:0] dec_left;

  assign b = item.data_byte;

  always_comb begin
    cur_phase      = phase;
    cur_tag_high   = tag_high;
    cur_bytes_left = bytes_left;
    cur_entries    = entries_seen;
    cur_match      = is_match;
    if (item.record_start) begin
      cur_phase      = bertlv_pkg::PhTag1;
      cur_tag_high   = 8'd0;
      cur_bytes_left = 8'd0;
      cur_entries    = 7'd0;
      cur_match      = 1'b0;
    end
    dec_left = cur_bytes_left - 8'd1;

    phase_next        = cur_phase;
    tag_high_next     = cur_tag_high;
    bytes_left_next   = cur_bytes_left;
    entries_seen_next = cur_entries;
    is_match_next     = cur_match;
    res_valid         = 1'b0;
    res               = '0;

    case (cur_phase)
      bertlv_pkg::PhTag1: begin
        if (b == 8'd0 || cur_entries >= EntryLimit) begin
          phase_next = bertlv_pkg::PhDone;
          res_valid  = 1'b1;
          res.last   = 1'b1;
        end else begin
          entries_seen_next = cur_entries + 7'd1;
          if (b[4:0] == bertlv_pkg::TagLongForm) begin
            tag_high_next = b;
            phase_next    = bertlv_pkg::PhTag2;
          end else begin
            is_match_next = (target_tag == {8'd0, b});
            phase_next    = bertlv_pkg::PhLen;
          end
        end
      end
      bertlv_pkg::PhTag2: begin
        is_match_next = (target_tag == {cur_tag_high, b});
        phase_next    = bertlv_pkg::PhLen;
      end
      bertlv_pkg::PhLen: begin
        bytes_left_next = b;
        if (cur_match) begin
          res_valid = 1'b1;
          if (b >= ValueLimit) begin
            phase_next = bertlv_pkg::PhDone;
            res.last   = 1'b1;
          end else begin
            phase_next    = (b == 8'd0) ? bertlv_pkg::PhDone : bertlv_pkg::PhCopy;
            res.out_byte  = b;
            res.is_length = 1'b1;
            res.found     = 1'b1;
            res.last      = (b == 8'd0);
          end
        end else begin
          phase_next = (b == 8'd0) ? bertlv_pkg::PhTag1 : bertlv_pkg::PhSkip;
        end
      end
      bertlv_pkg::PhSkip: begin
        bytes_left_next = dec_left;
        if (dec_left == 8'd0) begin
          phase_next = bertlv_pkg::PhTag1;
        end
      end
      bertlv_pkg::PhCopy: begin
        bytes_left_next = dec_left;
        res_valid       = 1'b1;
        res.out_byte    = b;
        res.found       = 1'b1;
        if (dec_left == 8'd0) begin
          phase_next = bertlv_pkg::PhDone;
          res.last   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= bertlv_pkg::PhTag1;
      tag_high     <= 8'd0;
      bytes_left   <= 8'd0;
      entries_seen <= 7'd0;
      is_match     <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      tag_high     <= tag_high_next;
      bytes_left   <= bytes_left_next;
      entries_seen <= entries_seen_next;
      is_match     <= is_match_next;
    end
  end

endmodule

// File: hw/rtl/bertlv_out_stage.sv
// result register of the tlv tag search block
// depends on bertlv_pkg

module bertlv_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                load,
  input  bertlv_pkg::result_t res,
  output logic                out_valid,
  input  logic                out_ready,
  output bertlv_pkg::result_t out_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      out_res <= res;
    end
  end

endmodule
